@@ src/gbn_sw_pkg.sv @@
package gbn_sw_pkg;

  localparam int unsigned SEQ_W = 14;
  localparam int unsigned CNT_W = 15;
  localparam int unsigned BYTES_W = 24;
  localparam int unsigned WIN_W = 5;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned RESULT_CAP = 16;
  localparam logic [CNT_W-1:0] SEQ_SPACE = 15'd16384;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_ACK = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SEQ_W-1:0]   ack_seq;
    logic [BYTES_W-1:0] file_bytes;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [SEQ_W-1:0] seq;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic apply_start;
    logic apply_ack;
    logic apply_tick;
    logic emit_send;
    logic emit_resend;
    logic emit_close;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       ack_ok;
    logic       ack_close;
    logic       active;
    logic       tick_timeout;
    logic       div_done;
    logic       cnt_zero;
    logic       fill_ok;
    logic       resend_ok;
    logic       slot_free;
  } dp_stat_t;

endpackage

@@ src/gbn_sw_div.sv @@
module gbn_sw_div #(
  parameter int unsigned DIVISOR = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [gbn_sw_pkg::BYTES_W-1:0]       dividend,
  output logic                                 done,
  output logic [gbn_sw_pkg::BYTES_W-1:0]       quot
);

  // The quotient is rounded up by adding DIVISOR - 1 first, then divided by
  // multiplying with a rounded-up reciprocal, which is exact for every sum.
  localparam int unsigned D_I = (DIVISOR < 1) ? 1 : DIVISOR;
  localparam int unsigned SUM_W = gbn_sw_pkg::BYTES_W + 1;
  localparam int unsigned LOG_D = $clog2(D_I);
  localparam int unsigned SHIFT = SUM_W + LOG_D;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_I =
    ((64'd1 << SHIFT) + 64'(D_I) - 64'd1) / 64'(D_I);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);
  localparam logic [SUM_W-1:0] BIAS = SUM_W'(D_I - 1);

  logic                 busy;
  logic [SUM_W-1:0]     sum;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    prod_sh;

  assign prod_sh = prod >> SHIFT;
  assign quot = prod_sh[gbn_sw_pkg::BYTES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
    if (start) begin
      sum <= {1'b0, dividend} + BIAS;
    end
    if (busy) begin
      prod <= PROD_W'(sum) * PROD_W'(RECIP);
    end
  end

endmodule

@@ src/gbn_sw_dp.sv @@
module gbn_sw_dp #(
  parameter int unsigned WIN_MAX = 16,
  parameter int unsigned PAYLOAD_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  gbn_sw_pkg::in_item_t                in_data,
  output gbn_sw_pkg::out_item_t               out_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  input  logic                                cfg_valid,
  input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  gbn_sw_pkg::dp_cmd_t                 cmd,
  output gbn_sw_pkg::dp_stat_t                stat
);

  localparam int unsigned WIN_LIM_I =
    (WIN_MAX > gbn_sw_pkg::RESULT_CAP) ? gbn_sw_pkg::RESULT_CAP :
    ((WIN_MAX < 1) ? 1 : WIN_MAX);
  localparam logic [gbn_sw_pkg::WIN_W-1:0] WIN_LIM = gbn_sw_pkg::WIN_W'(WIN_LIM_I);

  logic [gbn_sw_pkg::WIN_W-1:0]    window_size;
  logic [gbn_sw_pkg::TICK_W-1:0]   timeout_ticks;
  logic                            active;
  logic [gbn_sw_pkg::SEQ_W-1:0]    window_base;
  logic [gbn_sw_pkg::CNT_W-1:0]    next_seq;
  logic [gbn_sw_pkg::CNT_W-1:0]    packet_total;
  logic [gbn_sw_pkg::TICK_W-1:0]   idle_ticks;
  logic [gbn_sw_pkg::CNT_W-1:0]    resend_seq;
  gbn_sw_pkg::in_item_t            item;

  logic                            div_done;
  logic [gbn_sw_pkg::BYTES_W-1:0]  div_quot;
  logic [gbn_sw_pkg::CNT_W-1:0]    cnt;

  logic [gbn_sw_pkg::WIN_W-1:0]    eff_win;
  logic [gbn_sw_pkg::TICK_W-1:0]   tick_lim;
  logic [gbn_sw_pkg::TICK_W-1:0]   idle_sat;
  logic [gbn_sw_pkg::CNT_W-1:0]    ack_next;
  logic [gbn_sw_pkg::CNT_W-1:0]    outstanding;
  logic [gbn_sw_pkg::CNT_W:0]      seq_inc;
  logic                            fill_last;
  logic                            slot_free;

  gbn_sw_div #(
    .DIVISOR (PAYLOAD_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (item.file_bytes),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    if (div_quot > gbn_sw_pkg::BYTES_W'(gbn_sw_pkg::SEQ_SPACE)) begin
      cnt = gbn_sw_pkg::SEQ_SPACE;
    end else begin
      cnt = div_quot[gbn_sw_pkg::CNT_W-1:0];
    end

    if (window_size == '0) begin
      eff_win = gbn_sw_pkg::WIN_W'(1);
    end else if (window_size > WIN_LIM) begin
      eff_win = WIN_LIM;
    end else begin
      eff_win = window_size;
    end

    tick_lim = (timeout_ticks == '0) ? gbn_sw_pkg::TICK_W'(1) : timeout_ticks;
    idle_sat = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
    ack_next = {1'b0, item.ack_seq} + 1'b1;
    outstanding = next_seq - {1'b0, window_base};
    seq_inc = {1'b0, next_seq} + 1'b1;
    fill_last = (seq_inc >= {1'b0, packet_total})
             || ({1'b0, outstanding} + 1'b1 >= (gbn_sw_pkg::CNT_W + 1)'(eff_win));
    slot_free = !out_valid || out_ready;
  end

  always_comb begin
    stat.req = item.req_type;
    stat.ack_ok = active && (item.ack_seq >= window_base)
               && ({1'b0, item.ack_seq} < next_seq);
    stat.ack_close = (ack_next >= packet_total);
    stat.active = active;
    stat.tick_timeout = (idle_sat >= tick_lim);
    stat.div_done = div_done;
    stat.cnt_zero = (cnt == '0);
    stat.fill_ok = (next_seq < packet_total)
                && (outstanding < gbn_sw_pkg::CNT_W'(eff_win));
    stat.resend_ok = (resend_seq < next_seq);
    stat.slot_free = slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= gbn_sw_pkg::WIN_W'(5);
      timeout_ticks <= gbn_sw_pkg::TICK_W'(3);
      active <= 1'b0;
      window_base <= '0;
      next_seq <= '0;
      packet_total <= '0;
      idle_ticks <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          gbn_sw_pkg::REG_WINDOW_SIZE: window_size <= cfg_data[gbn_sw_pkg::WIN_W-1:0];
          gbn_sw_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.apply_start) begin
        packet_total <= cnt;
        window_base <= '0;
        next_seq <= '0;
        idle_ticks <= '0;
        active <= (cnt != '0);
      end

      if (cmd.apply_ack) begin
        idle_ticks <= '0;
        window_base <= ack_next[gbn_sw_pkg::SEQ_W-1:0];
        if (stat.ack_close) begin
          active <= 1'b0;
        end
      end

      if (cmd.apply_tick) begin
        if (stat.tick_timeout) begin
          idle_ticks <= '0;
        end else begin
          idle_ticks <= idle_sat;
        end
      end

      if (cmd.emit_send) begin
        next_seq <= seq_inc[gbn_sw_pkg::CNT_W-1:0];
      end

      if (cmd.emit_send || cmd.emit_resend || cmd.emit_close) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.apply_tick) begin
      resend_seq <= {1'b0, window_base};
    end else if (cmd.emit_resend) begin
      resend_seq <= resend_seq + 1'b1;
    end
    if (cmd.emit_send) begin
      out_data.kind <= gbn_sw_pkg::KIND_SEND;
      out_data.seq <= next_seq[gbn_sw_pkg::SEQ_W-1:0];
      out_data.last <= fill_last;
    end else if (cmd.emit_resend) begin
      out_data.kind <= gbn_sw_pkg::KIND_RESEND;
      out_data.seq <= resend_seq[gbn_sw_pkg::SEQ_W-1:0];
      out_data.last <= (resend_seq + 1'b1 == next_seq);
    end else if (cmd.emit_close) begin
      out_data.kind <= gbn_sw_pkg::KIND_CLOSE;
      out_data.seq <= '0;
      out_data.last <= 1'b1;
    end
  end

endmodule

@@ src/gbn_sw_ctrl.sv @@
module gbn_sw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gbn_sw_pkg::dp_stat_t  stat,
  output gbn_sw_pkg::dp_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_FILL,
    S_RESEND,
    S_CLOSE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (stat.req)
          gbn_sw_pkg::REQ_START: begin
            cmd.div_start = 1'b1;
            state_next = S_DIV;
          end
          gbn_sw_pkg::REQ_ACK: begin
            if (stat.ack_ok) begin
              cmd.apply_ack = 1'b1;
              state_next = stat.ack_close ? S_CLOSE : S_FILL;
            end
          end
          gbn_sw_pkg::REQ_TICK: begin
            if (stat.active) begin
              cmd.apply_tick = 1'b1;
              if (stat.tick_timeout) begin
                state_next = S_RESEND;
              end
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.apply_start = 1'b1;
          state_next = stat.cnt_zero ? S_CLOSE : S_FILL;
        end
      end
      S_FILL: begin
        if (!stat.fill_ok) begin
          state_next = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.emit_send = 1'b1;
        end
      end
      S_RESEND: begin
        if (!stat.resend_ok) begin
          state_next = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.emit_resend = 1'b1;
        end
      end
      S_CLOSE: begin
        if (stat.slot_free) begin
          cmd.emit_close = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/go_back_n_sender_window_unit.sv @@
// Go-back-N sender window unit. Requests enter on in_valid/in_ready: a start
// carrying a byte count, an acknowledgement carrying a sequence number, or a
// time tick. Send, resend and close commands leave on out_valid/out_ready, and
// the final command caused by one request has last set. The window size and
// timeout registers are written through cfg_valid/cfg_ready; the user must
// write them only while idle, as the block itself does not enforce this.
// A request is taken only in the idle state and is decoded in the next cycle.
// A start finds its packet count with a two-stage reciprocal multiplier, which
// registers the rounded-up sum and then the product before its first command.
// Commands follow one per cycle while the output is taken.
// The next request is taken only once the sequencer has issued every command
// of the last one and returned to idle.
// When the receiver stalls, the single output register holds its command and
// the sequencer waits; no command is lost or repeated.
// Reset clears the transfer state, empties the output register, and restores
// a window size of 5 and a timeout of 3 ticks; no clearing pass is needed.
module go_back_n_sender_window_unit #(
  parameter int unsigned WIN_MAX = 16,
  parameter int unsigned PAYLOAD_BYTES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gbn_sw_pkg::in_item_t                in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gbn_sw_pkg::out_item_t               out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gbn_sw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbn_sw_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gbn_sw_pkg::dp_cmd_t  cmd;
  gbn_sw_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  gbn_sw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbn_sw_dp #(
    .WIN_MAX       (WIN_MAX),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ dv/gbn_window_checker.sv @@
`timescale 1ns / 1ps

module gbn_window_checker
  import gbn_sw_pkg::*;
#(
  parameter int unsigned WIN_MAX = 16,
  parameter int unsigned PAYLOAD_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_total,
  output int                    cmds_outstanding,
  output int                    cmds_checked
);

  logic              xfer_active;
  logic [SEQ_W-1:0]  win_base;
  logic [CNT_W-1:0]  next_unsent;
  logic [CNT_W-1:0]  pkt_total;
  logic [TICK_W-1:0] idle_count;
  logic [WIN_W-1:0]  cfg_window;
  logic [TICK_W-1:0] cfg_timeout;

  out_item_t   expected_cmds[$];
  int unsigned item_cmds;

  function automatic int unsigned window_limit();
    int unsigned w;
    int unsigned cap;
    cap = (WIN_MAX < RESULT_CAP) ? WIN_MAX : RESULT_CAP;
    if (cap < 1) cap = 1;
    w = cfg_window;
    if (w < 1) w = 1;
    if (w > cap) w = cap;
    return w;
  endfunction

  task automatic queue_cmd(input logic [1:0] kind, input logic [SEQ_W-1:0] seq);
    out_item_t c;
    c.kind = kind;
    c.seq = seq;
    c.last = 1'b0;
    expected_cmds.push_back(c);
    item_cmds++;
  endtask

  task automatic refill_window();
    int unsigned w;
    w = window_limit();
    while (next_unsent < pkt_total && (32'(next_unsent) - 32'(win_base)) < w) begin
      queue_cmd(KIND_SEND, next_unsent[SEQ_W-1:0]);
      next_unsent++;
    end
  endtask

  task automatic predict_commands(input in_item_t r);
    int unsigned cnt;
    int unsigned nb;
    int unsigned lim;
    int unsigned s;
    out_item_t tail;
    item_cmds = 0;
    case (r.req_type)
      REQ_START: begin
        cnt = r.file_bytes / PAYLOAD_BYTES;
        if ((r.file_bytes % PAYLOAD_BYTES) != 0) cnt++;
        if (cnt > SEQ_SPACE) cnt = SEQ_SPACE;
        pkt_total = CNT_W'(cnt);
        win_base = '0;
        next_unsent = '0;
        idle_count = '0;
        if (cnt == 0) begin
          xfer_active = 1'b0;
          queue_cmd(KIND_CLOSE, '0);
        end else begin
          xfer_active = 1'b1;
          refill_window();
        end
      end
      REQ_ACK: begin
        if (xfer_active && r.ack_seq >= win_base && r.ack_seq < next_unsent) begin
          nb = 32'(r.ack_seq) + 1;
          idle_count = '0;
          win_base = nb[SEQ_W-1:0];
          if (nb >= pkt_total) begin
            xfer_active = 1'b0;
            queue_cmd(KIND_CLOSE, '0);
          end else begin
            refill_window();
          end
        end
      end
      REQ_TICK: begin
        if (xfer_active) begin
          lim = cfg_timeout;
          if (lim < 1) lim = 1;
          if (idle_count != '1) idle_count++;
          if (idle_count >= lim) begin
            idle_count = '0;
            for (s = win_base; s < next_unsent && item_cmds < RESULT_CAP; s++) begin
              queue_cmd(KIND_RESEND, SEQ_W'(s));
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (item_cmds > 0) begin
      tail = expected_cmds.pop_back();
      tail.last = 1'b1;
      expected_cmds.push_back(tail);
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      xfer_active = 1'b0;
      win_base = '0;
      next_unsent = '0;
      pkt_total = '0;
      idle_count = '0;
      cfg_window = WIN_W'(5);
      cfg_timeout = TICK_W'(3);
      expected_cmds.delete();
      mismatch_total = 0;
      cmds_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_SIZE:   cfg_window = cfg_data[WIN_W-1:0];
          REG_TIMEOUT_TICKS: cfg_timeout = cfg_data[TICK_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) predict_commands(in_data);
      if (out_valid && out_ready) begin
        cmds_checked++;
        if (expected_cmds.size() == 0) begin
          $error("unexpected command: kind %0d seq %0d last %0d",
                 out_data.kind, out_data.seq, out_data.last);
          mismatch_total++;
        end else begin
          want = expected_cmds.pop_front();
          if (out_data.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_data.kind);
            mismatch_total++;
          end
          if (out_data.seq !== want.seq) begin
            $error("seq: expected %0d, actual %0d", want.seq, out_data.seq);
            mismatch_total++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_data.last);
            mismatch_total++;
          end
        end
      end
    end
    cmds_outstanding <= expected_cmds.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import gbn_sw_pkg::*;

  localparam int unsigned WIN_MAX = 16;
  localparam int unsigned PAYLOAD_BYTES = 1024;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int NUM_SETTINGS = 9;
  localparam int ITEMS_PER_SETTING = 51;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatch_total;
  int cmds_outstanding;
  int cmds_checked;

  int unsigned win_set[NUM_SETTINGS] = '{0, 1, 16, 31, 17, 8, 2, 12, 5};
  int unsigned tmo_set[NUM_SETTINGS] = '{0, 1, 2, 65535, 7, 0, 4, 1, 3};

  int unsigned burst_left = 0;
  int unsigned gap_max = 4;
  int unsigned ready_run = 0;
  bit no_stall = 1'b0;
  int req_count = 0;
  int settings_done = 0;

  // Stimulus-side view of the transfer, used to aim acknowledgements and to favour starts while no transfer is active.
  bit tx_active = 1'b0;
  int unsigned tx_base = 0;
  int unsigned tx_total = 0;
  int unsigned tx_win = 5;

  go_back_n_sender_window_unit #(
    .WIN_MAX(WIN_MAX),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  gbn_window_checker #(
    .WIN_MAX(WIN_MAX),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_total(mismatch_total),
    .cmds_outstanding(cmds_outstanding),
    .cmds_checked(cmds_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || no_stall) begin
      out_ready <= 1'b1;
    end else if (ready_run == 0) begin
      ready_run = $urandom_range(1, 20);
      out_ready <= ($urandom_range(0, 3) != 0);
    end else begin
      ready_run--;
    end
  end

  function automatic in_item_t mk(input logic [1:0] req, input logic [SEQ_W-1:0] ack,
                                  input logic [BYTES_W-1:0] bytes);
    in_item_t it;
    it.req_type = req;
    it.ack_seq = ack;
    it.file_bytes = bytes;
    return it;
  endfunction

  task automatic push_request(input in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    req_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (cmds_outstanding != 0);
  endtask

  task automatic apply_setting(input int unsigned win, input int unsigned tmo);
    settle();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_WINDOW_SIZE;
    cfg_data <= CFG_DATA_W'(($urandom_range(0, 2047) << WIN_W) | win);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_data <= CFG_DATA_W'(tmo);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tx_win = (win < 1) ? 1 : ((win > WIN_MAX) ? WIN_MAX : win);
    tx_active = 1'b0;
    settings_done++;
  endtask

  task automatic pick_request(output in_item_t it);
    int unsigned roll;
    int unsigned nxt;
    int unsigned cnt;
    it.req_type = 2'($urandom_range(0, 3));
    it.ack_seq = SEQ_W'($urandom_range(0, 16383));
    it.file_bytes = BYTES_W'($urandom_range(0, 24'hFFFFFF));
    roll = $urandom_range(0, 99);
    nxt = tx_base + tx_win;
    if (nxt > tx_total) nxt = tx_total;
    if (!tx_active) begin
      if (roll < 80) it.req_type = REQ_START;
    end else if (roll < 55) begin
      it.req_type = REQ_ACK;
      it.ack_seq = SEQ_W'($urandom_range(tx_base, nxt - 1));
    end else if (roll < 80) begin
      it.req_type = REQ_TICK;
    end else if (roll < 88) begin
      it.req_type = REQ_ACK;
      if (tx_base > 0 && ($urandom_range(0, 1) == 0 || nxt > 16383)) begin
        it.ack_seq = SEQ_W'($urandom_range(0, tx_base - 1));
      end else if (nxt <= 16383) begin
        it.ack_seq = SEQ_W'($urandom_range(nxt, 16383));
      end else begin
        it.req_type = REQ_TICK;
      end
    end else if (roll < 93) begin
      it.req_type = REQ_START;
    end
    if (it.req_type == REQ_START) begin
      case ($urandom_range(0, 19))
        0: it.file_bytes = BYTES_W'($urandom_range(0, 24'hFFFFFF));
        1: it.file_bytes = '0;
        2: it.file_bytes = BYTES_W'($urandom_range(1, 12) * PAYLOAD_BYTES);
        default: it.file_bytes = BYTES_W'($urandom_range(1, 12 * PAYLOAD_BYTES));
      endcase
      cnt = it.file_bytes / PAYLOAD_BYTES;
      if ((it.file_bytes % PAYLOAD_BYTES) != 0) cnt++;
      if (cnt > SEQ_SPACE) cnt = SEQ_SPACE;
      tx_total = cnt;
      tx_base = 0;
      tx_active = (cnt != 0);
    end else if (it.req_type == REQ_ACK && tx_active && it.ack_seq >= tx_base
                 && it.ack_seq < nxt) begin
      tx_base = it.ack_seq + 1;
      if (tx_base >= tx_total) tx_active = 1'b0;
    end
  endtask

  initial begin
    in_item_t it;
    int p;
    int i;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    push_request(mk(REQ_ACK, '0, '0));
    push_request(mk(REQ_TICK, '1, '1));
    push_request(mk(REQ_UNUSED, '1, '1));
    push_request(mk(REQ_START, '0, '0));
    push_request(mk(REQ_START, '0, 24'd1));
    push_request(mk(REQ_ACK, '0, '0));
    push_request(mk(REQ_START, '0, 24'd1024));
    repeat (3) push_request(mk(REQ_TICK, '0, '0));
    push_request(mk(REQ_ACK, 14'd1, '0));
    push_request(mk(REQ_ACK, '1, '0));
    push_request(mk(REQ_ACK, '0, '0));
    push_request(mk(REQ_START, '1, '1));
    push_request(mk(REQ_ACK, 14'd2, '0));
    push_request(mk(REQ_ACK, 14'd1, '0));
    repeat (3) push_request(mk(REQ_TICK, '0, '0));
    push_request(mk(REQ_START, '0, 24'd5121));
    push_request(mk(REQ_ACK, 14'd4, '0));
    push_request(mk(REQ_ACK, 14'd5, '0));
    push_request(mk(REQ_START, '0, 24'd1025));
    push_request(mk(REQ_ACK, 14'd1, '0));

    for (p = 0; p < NUM_SETTINGS; p++) begin
      apply_setting(win_set[p], tmo_set[p]);
      no_stall = (p % 4 == 1);
      gap_max = (p % 3 == 2) ? 0 : 6;
      for (i = 0; i < ITEMS_PER_SETTING; i++) begin
        pick_request(it);
        push_request(it);
        if ((p == 0 && i == 20) || $urandom_range(0, 39) == 0) settle();
      end
    end

    settle();
    repeat (40) @(posedge clk);
    $display("Run covered %0d requests and %0d checked commands over %0d register settings,",
             req_count, cmds_checked, settings_done);
    $display("with window sizes from 0 to 31 and timeouts from 0 to 65535.");
    if (mismatch_total == 0 && cmds_outstanding == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
